/* sv/cdsp_pkg.sv */
// ----------------------------------------------------------------------------
// cdsp_pkg: shared definitions for the 2D convolution block
// Field widths, configuration register indexes, request kinds, default
// store sizes and the saturation helpers used across the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdsp_pkg;

    // Request and response field widths.
    localparam int KIND_W = 2;
    localparam int CH_W   = 3;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int FLT_W  = 3;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 40;

    // Product and accumulator widths. The accumulator holds the exact sum
    // of up to 15 channels of 7 by 7 taps before it is saturated.
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam int ROWS_REG_W  = 6;
    localparam int COLS_REG_W  = 6;
    localparam int CHAN_REG_W  = 4;
    localparam int KSIZE_REG_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd3;

    // Register values after reset, before saturation to the store sizes.
    localparam int RST_IMAGE_ROWS    = 32;
    localparam int RST_IMAGE_COLS    = 32;
    localparam int RST_CHANNEL_COUNT = 1;
    localparam int RST_KERNEL_SIZE   = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Default store sizes.
    localparam int DEF_MAX_ROWS     = 32;
    localparam int DEF_MAX_COLS     = 32;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_FILTERS  = 8;
    localparam int DEF_MAX_KERNEL   = 5;

    // Signed 40-bit range expressed at accumulator width.
    localparam logic signed [ACC_W-1:0] ACC_SUM_MAX = 48'sh007F_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_SUM_MIN = 48'shFF80_0000_0000;

    // Saturate a register value into the range one to hi.
    function automatic int sat_reg(input int v, input int hi);
        int r;
        r = v;
        if (v < 1)
        begin
            r = 1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cdsp_if.sv */
// ----------------------------------------------------------------------------
// cdsp_if: request and response channels of the convolution block
// Each channel carries valid, ready and its payload; a request or response
// moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdsp_req_if;
    logic                               valid;
    logic                               ready;
    logic        [cdsp_pkg::KIND_W-1:0] kind;
    logic        [cdsp_pkg::CH_W-1:0]   channel;
    logic        [cdsp_pkg::ROW_W-1:0]  row;
    logic        [cdsp_pkg::COL_W-1:0]  col;
    logic        [cdsp_pkg::FLT_W-1:0]  filter_index;
    logic signed [cdsp_pkg::VAL_W-1:0]  value;

    modport source (output valid, output kind, output channel, output row,
                    output col, output filter_index, output value, input ready);
    modport sink   (input valid, input kind, input channel, input row,
                    input col, input filter_index, input value, output ready);
endinterface

interface cdsp_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [cdsp_pkg::FLT_W-1:0]  out_filter;
    logic        [cdsp_pkg::ROW_W-1:0]  out_row;
    logic        [cdsp_pkg::COL_W-1:0]  out_col;
    logic signed [cdsp_pkg::SUM_W-1:0]  sum;
    logic                               error;

    modport source (output valid, output out_filter, output out_row, output out_col,
                    output sum, output error, input ready);
    modport sink   (input valid, input out_filter, input out_row, input out_col,
                    input sum, input error, output ready);
endinterface

`default_nettype wire

/* sv/cdsp_ram.sv */
// ----------------------------------------------------------------------------
// cdsp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdsp_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/conv2d_same_padding_top.sv */
// An in-range write request goes straight into its store and ready stays high.
// A compute request feeds one tap a cycle to the single shared
// multiply-accumulate unit, then drains the pipeline. An out-of-range
// request answers with an error response. A stalled previous response
// holds a new response back and keeps ready low. Reset (rst_n low, async)
// clears control and restores the registers; the stores are undefined until written.
// ----------------------------------------------------------------------------
// conv2d_same_padding_top: multichannel 2D convolution, stride one
// Fills the weight and image stores from write requests and computes one
// output element per compute request with zero padding on every edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv2d_same_padding_top #(
    parameter int MAX_ROWS     = cdsp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = cdsp_pkg::DEF_MAX_COLS,
    parameter int MAX_CHANNELS = cdsp_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_FILTERS  = cdsp_pkg::DEF_MAX_FILTERS,
    parameter int MAX_KERNEL   = cdsp_pkg::DEF_MAX_KERNEL
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cdsp_req_if.sink                           req,
    cdsp_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [cdsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import cdsp_pkg::*;

    localparam int IMG_DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int IAW       = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WAW       = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Configuration registers.
    logic [ROWS_REG_W-1:0]  rows_reg;
    logic [COLS_REG_W-1:0]  cols_reg;
    logic [CHAN_REG_W-1:0]  chan_reg;
    logic [KSIZE_REG_W-1:0] ks_reg;

    // Sequencer state.
    logic [1:0]             state_reg, state_next;
    logic [CHAN_REG_W-1:0]  ch_cnt_reg, ch_cnt_next;
    logic [KSIZE_REG_W-1:0] kr_cnt_reg, kr_cnt_next;
    logic [KSIZE_REG_W-1:0] kc_cnt_reg, kc_cnt_next;
    logic                   vld_q1_reg, vld_q1_next;
    logic                   last_q1_reg, last_q1_next;
    logic                   vld_q2_reg, vld_q2_next;
    logic                   last_q2_reg, last_q2_next;
    logic                   out_valid_reg, out_valid_next;

    // Request echo, product and accumulator.
    logic [FLT_W-1:0]         f_reg, f_next;
    logic [ROW_W-1:0]         r_reg, r_next;
    logic [COL_W-1:0]         c_reg, c_next;
    logic                     err_reg, err_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // Output register.
    logic [FLT_W-1:0]         out_filter_reg, out_filter_next;
    logic [ROW_W-1:0]         out_row_reg, out_row_next;
    logic [COL_W-1:0]         out_col_reg, out_col_next;
    logic signed [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic                     out_err_reg, out_err_next;

    // Store ports.
    logic             img_we, wgt_we;
    logic [IAW-1:0]   img_waddr, img_raddr;
    logic [WAW-1:0]   wgt_waddr, wgt_raddr;
    logic [VAL_W-1:0] img_rdata, wgt_rdata;

    logic             req_fire;
    logic             out_free;
    logic             wgt_ok, pix_ok, cmp_ok;
    logic [KSIZE_REG_W-1:0] pad;
    logic [7:0]       tap_row, tap_col;
    logic             tap_ok;
    logic             kc_last, kr_last, ch_last;
    logic signed [SUM_W-1:0] sat_sum;

    // Configuration writes, saturated into each register's legal range.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_REG_W'(sat_reg(RST_IMAGE_ROWS, MAX_ROWS));
            cols_reg <= COLS_REG_W'(sat_reg(RST_IMAGE_COLS, MAX_COLS));
            chan_reg <= CHAN_REG_W'(sat_reg(RST_CHANNEL_COUNT, MAX_CHANNELS));
            ks_reg   <= KSIZE_REG_W'(sat_reg(RST_KERNEL_SIZE, MAX_KERNEL));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_ROWS:
                begin
                    rows_reg <= ROWS_REG_W'(sat_reg(int'(cfg_data), MAX_ROWS));
                end
                CFG_IMAGE_COLS:
                begin
                    cols_reg <= COLS_REG_W'(sat_reg(int'(cfg_data), MAX_COLS));
                end
                CFG_CHANNEL_COUNT:
                begin
                    chan_reg <= CHAN_REG_W'(sat_reg(int'(cfg_data[CHAN_REG_W-1:0]),
                                                    MAX_CHANNELS));
                end
                CFG_KERNEL_SIZE:
                begin
                    ks_reg <= KSIZE_REG_W'(sat_reg(int'(cfg_data[KSIZE_REG_W-1:0]),
                                                   MAX_KERNEL));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Range checks on an incoming request.
    assign wgt_ok = (int'(req.filter_index) < MAX_FILTERS)
                 && ({1'b0, req.channel} < chan_reg)
                 && (req.row < {2'b00, ks_reg})
                 && (req.col < {2'b00, ks_reg});
    assign pix_ok = ({1'b0, req.channel} < chan_reg)
                 && ({1'b0, req.row} < rows_reg)
                 && ({1'b0, req.col} < cols_reg);
    assign cmp_ok = (int'(req.filter_index) < MAX_FILTERS)
                 && ({1'b0, req.row} < rows_reg)
                 && ({1'b0, req.col} < cols_reg);

    // Store writes straight from the request.
    assign img_we    = req_fire && (req.kind == KIND_PIXEL) && pix_ok;
    assign wgt_we    = req_fire && (req.kind == KIND_WEIGHT) && wgt_ok;
    assign img_waddr = IAW'((int'(req.channel) * MAX_ROWS + int'(req.row)) * MAX_COLS
                            + int'(req.col));
    assign wgt_waddr = WAW'(((int'(req.filter_index) * MAX_CHANNELS + int'(req.channel))
                             * MAX_KERNEL + int'(req.row)) * MAX_KERNEL + int'(req.col));

    // Tap geometry: image position under the current kernel tap.
    assign pad     = (ks_reg - 3'd1) >> 1;
    assign tap_row = {3'b000, r_reg} + {5'b00000, kr_cnt_reg} - {5'b00000, pad};
    assign tap_col = {3'b000, c_reg} + {5'b00000, kc_cnt_reg} - {5'b00000, pad};
    assign tap_ok  = !tap_row[7] && (tap_row[6:0] < {1'b0, rows_reg})
                  && !tap_col[7] && (tap_col[6:0] < {1'b0, cols_reg});

    assign kc_last = (kc_cnt_reg == ks_reg - 3'd1);
    assign kr_last = (kr_cnt_reg == ks_reg - 3'd1);
    assign ch_last = (ch_cnt_reg == chan_reg - 4'd1);

    assign img_raddr = IAW'((int'(ch_cnt_reg) * MAX_ROWS + int'(tap_row[6:0])) * MAX_COLS
                            + int'(tap_col[6:0]));
    assign wgt_raddr = WAW'(((int'(f_reg) * MAX_CHANNELS + int'(ch_cnt_reg)) * MAX_KERNEL
                             + int'(kr_cnt_reg)) * MAX_KERNEL + int'(kc_cnt_reg));

    // Image and weight stores.
    cdsp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (IMG_DEPTH)
    ) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (req.value),
        .re    ((state_reg == ST_RUN) && tap_ok),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    cdsp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WGT_DEPTH)
    ) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (req.value),
        .re    ((state_reg == ST_RUN) && tap_ok),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    // Final sum saturated to the signed 40-bit range.
    always_comb
    begin
        if (acc_reg > ACC_SUM_MAX)
        begin
            sat_sum = ACC_SUM_MAX[SUM_W-1:0];
        end
        else if (acc_reg < ACC_SUM_MIN)
        begin
            sat_sum = ACC_SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            sat_sum = acc_reg[SUM_W-1:0];
        end
    end

    // Sequencer and multiply-accumulate pipeline.
    always_comb
    begin
        state_next      = state_reg;
        ch_cnt_next     = ch_cnt_reg;
        kr_cnt_next     = kr_cnt_reg;
        kc_cnt_next     = kc_cnt_reg;
        f_next          = f_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        err_next        = err_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_filter_next = out_filter_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_sum_next    = out_sum_reg;
        out_err_next    = out_err_reg;

        // Tap issue, multiply, then accumulate, one stage each.
        vld_q1_next  = (state_reg == ST_RUN) && tap_ok;
        last_q1_next = (state_reg == ST_RUN) && kc_last && kr_last && ch_last;
        vld_q2_next  = vld_q1_reg;
        last_q2_next = last_q1_reg;
        prod_next    = vld_q1_reg ? PROD_W'($signed(wgt_rdata) * $signed(img_rdata))
                                  : '0;
        if (vld_q2_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    f_next = req.filter_index;
                    r_next = req.row;
                    c_next = req.col;
                    case (req.kind)
                        KIND_WEIGHT:
                        begin
                            if (!wgt_ok)
                            begin
                                err_next   = 1'b1;
                                acc_next   = '0;
                                state_next = ST_DONE;
                            end
                        end
                        KIND_PIXEL:
                        begin
                            if (!pix_ok)
                            begin
                                err_next   = 1'b1;
                                acc_next   = '0;
                                state_next = ST_DONE;
                            end
                        end
                        KIND_COMPUTE:
                        begin
                            acc_next    = '0;
                            ch_cnt_next = '0;
                            kr_cnt_next = '0;
                            kc_cnt_next = '0;
                            err_next    = !cmp_ok;
                            state_next  = cmp_ok ? ST_RUN : ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // Step column, then row, then channel.
                if (kc_last)
                begin
                    kc_cnt_next = '0;
                    if (kr_last)
                    begin
                        kr_cnt_next = '0;
                        if (ch_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            ch_cnt_next = ch_cnt_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        kr_cnt_next = kr_cnt_reg + 3'd1;
                    end
                end
                else
                begin
                    kc_cnt_next = kc_cnt_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                if (last_q2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_filter_next = f_reg;
                    out_row_next    = r_reg;
                    out_col_next    = c_reg;
                    out_sum_next    = sat_sum;
                    out_err_next    = err_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_cnt_reg    <= '0;
            kr_cnt_reg    <= '0;
            kc_cnt_reg    <= '0;
            vld_q1_reg    <= 1'b0;
            last_q1_reg   <= 1'b0;
            vld_q2_reg    <= 1'b0;
            last_q2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_cnt_reg    <= ch_cnt_next;
            kr_cnt_reg    <= kr_cnt_next;
            kc_cnt_reg    <= kc_cnt_next;
            vld_q1_reg    <= vld_q1_next;
            last_q1_reg   <= last_q1_next;
            vld_q2_reg    <= vld_q2_next;
            last_q2_reg   <= last_q2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        f_reg          <= f_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        err_reg        <= err_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        out_filter_reg <= out_filter_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_sum_reg    <= out_sum_next;
        out_err_reg    <= out_err_next;
    end

    // Response channel.
    assign rsp.valid      = out_valid_reg;
    assign rsp.out_filter = out_filter_reg;
    assign rsp.out_row    = out_row_reg;
    assign rsp.out_col    = out_col_reg;
    assign rsp.sum        = out_sum_reg;
    assign rsp.error      = out_err_reg;

endmodule

`default_nettype wire

/* sv/cdsp_checker.sv */
// ----------------------------------------------------------------------------
// cdsp_checker: port-level assertions for the convolution block
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdsp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic [cdsp_pkg::KIND_W-1:0]       req_kind,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [cdsp_pkg::FLT_W-1:0]        rsp_out_filter,
    input  logic [cdsp_pkg::ROW_W-1:0]        rsp_out_row,
    input  logic [cdsp_pkg::COL_W-1:0]        rsp_out_col,
    input  logic signed [cdsp_pkg::SUM_W-1:0] rsp_sum,
    input  logic                              rsp_error
);

    import cdsp_pkg::*;

    // A stalled response stays valid.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_out_filter) && $stable(rsp_out_row)
                                    && $stable(rsp_out_col) && $stable(rsp_sum)
                                    && $stable(rsp_error))
        else $error("response payload changed while stalled");

    // A compute request occupies the block for at least the next cycle.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_kind == KIND_COMPUTE) |=> !req_ready)
        else $error("request taken right after a compute request");

    // An error response always carries a zero sum.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error |-> (rsp_sum == '0))
        else $error("error response with nonzero sum");

endmodule

bind conv2d_same_padding_top cdsp_checker u_cdsp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_kind       (req.kind),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_out_filter (rsp.out_filter),
    .rsp_out_row    (rsp.out_row),
    .rsp_out_col    (rsp.out_col),
    .rsp_sum        (rsp.sum),
    .rsp_error      (rsp.error)
);

`default_nettype wire

/* test/conv2d_checker.sv */
// ----------------------------------------------------------------------------
// conv2d_checker: response predictor and comparator for the convolution block
// Watches the request, response and register write ports, keeps its own copy
// of the image and weight stores and the register settings, predicts the
// response, if any, of every accepted request and compares each accepted response,
// field by field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv2d_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    cdsp_req_if                             req,
    cdsp_rsp_if                             rsp,
    input  logic                            cfg_we,
    input  logic [cdsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending_count,
    output int                              checked_count,
    output int                              cur_rows,
    output int                              cur_cols,
    output int                              cur_chans,
    output int                              cur_ksize
);

    import cdsp_pkg::*;

    // Largest and smallest sum that fits the 40-bit response field.
    localparam longint SUM_HIGH = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LOW  = -SUM_HIGH - 1;

    typedef struct packed {
        logic [FLT_W-1:0]        filter;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    error;
    } conv_result_t;

    // Shadow stores, addressed at the maximum sizes like the block's own.
    logic signed [VAL_W-1:0] pixel_mem  [DEF_MAX_CHANNELS][DEF_MAX_ROWS][DEF_MAX_COLS];
    logic signed [VAL_W-1:0] weight_mem [DEF_MAX_FILTERS][DEF_MAX_CHANNELS]
                                        [DEF_MAX_KERNEL][DEF_MAX_KERNEL];

    // Register settings as they stand after saturation.
    int rows_cfg  = RST_IMAGE_ROWS;
    int cols_cfg  = RST_IMAGE_COLS;
    int chans_cfg = RST_CHANNEL_COUNT;
    int ksize_cfg = RST_KERNEL_SIZE;

    conv_result_t expected_results[$];
    int           mismatches = 0;
    int           responses_seen = 0;

    // A register value of zero becomes one, anything above the maximum
    // becomes the maximum.
    function automatic int clamp_setting(input int raw, input int hi);
        if (raw < 1)
        begin
            return 1;
        end
        if (raw > hi)
        begin
            return hi;
        end
        return raw;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Applies one request to the shadow stores and works out the response it
    // causes, if any. Returns one when a response is due.
    function automatic bit predict_conv_response(input logic [KIND_W-1:0] kind,
                                                 input logic [CH_W-1:0] channel,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col,
                                                 input logic [FLT_W-1:0] filt,
                                                 input logic signed [VAL_W-1:0] value,
                                                 output conv_result_t result);
        bit     in_range;
        longint acc;
        int     pad;
        int     ir;
        int     ic;
        in_range = 1'b0;
        acc = 0;
        result.filter = filt;
        result.row = row;
        result.col = col;
        case (kind)
            KIND_WEIGHT:
            begin
                in_range = int'(filt) < DEF_MAX_FILTERS && int'(channel) < chans_cfg &&
                           int'(row) < ksize_cfg && int'(col) < ksize_cfg;
                if (in_range)
                begin
                    weight_mem[filt][channel][row][col] = value;
                    return 1'b0;
                end
            end
            KIND_PIXEL:
            begin
                in_range = int'(channel) < chans_cfg && int'(row) < rows_cfg &&
                           int'(col) < cols_cfg;
                if (in_range)
                begin
                    pixel_mem[channel][row][col] = value;
                    return 1'b0;
                end
            end
            KIND_COMPUTE:
            begin
                in_range = int'(filt) < DEF_MAX_FILTERS && int'(row) < rows_cfg &&
                           int'(col) < cols_cfg;
                if (in_range)
                begin
                    // The window is offset up and left by pad; taps past any edge read zero.
                    pad = (ksize_cfg - 1) / 2;
                    for (int ch = 0; ch < chans_cfg; ch++)
                    begin
                        for (int kr = 0; kr < ksize_cfg; kr++)
                        begin
                            ir = int'(row) + kr - pad;
                            if (ir < 0 || ir >= rows_cfg)
                            begin
                                continue;
                            end
                            for (int kc = 0; kc < ksize_cfg; kc++)
                            begin
                                ic = int'(col) + kc - pad;
                                if (ic < 0 || ic >= cols_cfg)
                                begin
                                    continue;
                                end
                                acc += longint'(weight_mem[filt][ch][kr][kc]) *
                                       longint'(pixel_mem[ch][ir][ic]);
                            end
                        end
                    end
                end
            end
            default:
            begin
                // The unused kind is dropped without a response.
                return 1'b0;
            end
        endcase
        if (acc > SUM_HIGH)
        begin
            acc = SUM_HIGH;
        end
        if (acc < SUM_LOW)
        begin
            acc = SUM_LOW;
        end
        result.sum = SUM_W'(acc);
        result.error = !in_range;
        return 1'b1;
    endfunction

    // Responses are matched before new requests are predicted: no response
    // can belong to a request accepted at the same edge.
    always @(posedge clk)
    begin
        conv_result_t oldest;
        conv_result_t fresh;
        if (rst_n)
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("response with no request outstanding: filter %0d row %0d col %0d",
                           rsp.out_filter, rsp.out_row, rsp.out_col);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("out_filter", oldest.filter, rsp.out_filter);
                    check_field("out_row", oldest.row, rsp.out_row);
                    check_field("out_col", oldest.col, rsp.out_col);
                    check_field("sum", oldest.sum, rsp.sum);
                    check_field("error", oldest.error, rsp.error);
                    responses_seen++;
                end
            end

            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    CFG_IMAGE_ROWS:
                        rows_cfg = clamp_setting(int'(cfg_data[ROWS_REG_W-1:0]), DEF_MAX_ROWS);
                    CFG_IMAGE_COLS:
                        cols_cfg = clamp_setting(int'(cfg_data[COLS_REG_W-1:0]), DEF_MAX_COLS);
                    CFG_CHANNEL_COUNT:
                        chans_cfg = clamp_setting(int'(cfg_data[CHAN_REG_W-1:0]),
                                                  DEF_MAX_CHANNELS);
                    CFG_KERNEL_SIZE:
                        ksize_cfg = clamp_setting(int'(cfg_data[KSIZE_REG_W-1:0]),
                                                  DEF_MAX_KERNEL);
                    default:
                    begin
                    end
                endcase
            end

            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                if (predict_conv_response(req.kind, req.channel, req.row, req.col,
                                          req.filter_index, req.value, fresh))
                begin
                    expected_results = {expected_results, fresh};
                end
            end
        end

        // Exported with nonblocking updates so readers see the pre-edge value.
        fail_count    <= mismatches;
        pending_count <= expected_results.size();
        checked_count <= responses_seen;
        cur_rows      <= rows_cfg;
        cur_cols      <= cols_cfg;
        cur_chans     <= chans_cfg;
        cur_ksize     <= ksize_cfg;
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the 2D convolution block
// Runs a directed set of corner requests at the reset settings, then a series
// of register settings, each filling the stores it needs and following with
// random computes, writes and out-of-range requests under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cdsp_pkg::*;

    localparam int     CLK_PERIOD   = 20;
    localparam int     RESET_CYCLES = 9;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     QUIET_CYCLES = DEF_MAX_CHANNELS * DEF_MAX_KERNEL * DEF_MAX_KERNEL + 16;
    localparam longint TIMEOUT_NS   = 20_000_000;

    localparam logic [KIND_W-1:0]    KIND_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

    localparam logic signed [VAL_W-1:0] VALUE_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VALUE_MIN = 16'sh8000;

    // Weights of filter zero for the corner computes at the reset settings.
    localparam logic signed [VAL_W-1:0] CORNER_WEIGHTS [9] = '{
        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh1000,
        16'shFFFF, 16'sh0001, 16'sh0000, 16'sh3039
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int cur_rows;
    int cur_cols;
    int cur_chans;
    int cur_ksize;

    int requests_sent  = 0;
    int computes_sent  = 0;
    int settings_used  = 1;
    int no_idle_left   = 0;
    int hold_requests  = 0;
    int holds_served   = 0;

    cdsp_req_if req_ch ();
    cdsp_rsp_if rsp_ch ();

    conv2d_same_padding_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv2d_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .cur_rows      (cur_rows),
        .cur_cols      (cur_cols),
        .cur_chans     (cur_chans),
        .cur_ksize     (cur_ksize)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle cycles before the next request: mostly none or a few, now and then
    // a long gap, and occasional runs with no gaps at all.
    function automatic int idle_cycles();
        int roll;
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            no_idle_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sample values lean toward the two extremes of Q4.12.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            return VALUE_MAX;
        end
        if (roll < 16)
        begin
            return VALUE_MIN;
        end
        return VAL_W'($urandom);
    endfunction

    // Offers one request and returns at the edge where it is accepted; valid
    // stays high so that a following request can go out without a gap.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [CH_W-1:0] channel,
                                input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col,
                                input logic [FLT_W-1:0] filt,
                                input logic signed [VAL_W-1:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.channel      <= channel;
        req_ch.row          <= row;
        req_ch.col          <= col;
        req_ch.filter_index <= filt;
        req_ch.value        <= value;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        requests_sent++;
        if (kind == KIND_COMPUTE)
        begin
            computes_sent++;
        end
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] index, input int raw);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(raw);
        @(posedge clk);
    endtask

    // Waits until every response is in, then lets the block finish any write
    // still in flight. The first edge lets the count take in the request
    // accepted at the edge this task is called from.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // One register setting: program it while idle, fill the pixels in use and
    // the weights of two filters, then run random traffic against it.
    task automatic run_phase(input int rows_raw, input int cols_raw,
                             input int chans_raw, input int ksize_raw,
                             input int random_count, input bit with_hold);
        int               rows;
        int               cols;
        int               chans;
        int               ksize;
        int               roll;
        logic [FLT_W-1:0] filt_a;
        logic [FLT_W-1:0] filt_b;
        logic [FLT_W-1:0] filt;
        wait_until_idle();
        write_setting(CFG_IMAGE_ROWS, rows_raw);
        write_setting(CFG_IMAGE_COLS, cols_raw);
        write_setting(CFG_CHANNEL_COUNT, chans_raw);
        write_setting(CFG_KERNEL_SIZE, ksize_raw);
        write_setting(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 3)),
                      $urandom_range(0, 63));
        cfg_we <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        rows  = cur_rows;
        cols  = cur_cols;
        chans = cur_chans;
        ksize = cur_ksize;
        settings_used++;

        // Fill everything a valid compute on the chosen filters can touch.
        filt_a = FLT_W'($urandom_range(0, 7));
        filt_b = filt_a + FLT_W'($urandom_range(1, 7));
        for (int ch = 0; ch < chans; ch++)
        begin
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < cols; c++)
                begin
                    send_request(KIND_PIXEL, CH_W'(ch), ROW_W'(r), COL_W'(c),
                                 FLT_W'($urandom), pick_value());
                end
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            filt = (k == 0) ? filt_a : filt_b;
            for (int ch = 0; ch < chans; ch++)
            begin
                for (int kr = 0; kr < ksize; kr++)
                begin
                    for (int kc = 0; kc < ksize; kc++)
                    begin
                        send_request(KIND_WEIGHT, CH_W'(ch), ROW_W'(kr), COL_W'(kc),
                                     filt, pick_value());
                    end
                end
            end
        end

        // Mostly valid computes and in-range rewrites, the rest out of range
        // or plain noise.
        for (int i = 0; i < random_count; i++)
        begin
            if (with_hold && i == random_count / 4)
            begin
                hold_requests++;
            end
            roll = $urandom_range(0, 99);
            if (roll >= 72 && roll < 82 && (rows < DEF_MAX_ROWS || cols < DEF_MAX_COLS))
            begin
                if (rows < DEF_MAX_ROWS)
                begin
                    send_request(KIND_COMPUTE, CH_W'($urandom),
                                 ROW_W'($urandom_range(rows, DEF_MAX_ROWS - 1)),
                                 COL_W'($urandom), FLT_W'($urandom), VAL_W'($urandom));
                end
                else
                begin
                    send_request(KIND_COMPUTE, CH_W'($urandom), ROW_W'($urandom),
                                 COL_W'($urandom_range(cols, DEF_MAX_COLS - 1)),
                                 FLT_W'($urandom), VAL_W'($urandom));
                end
            end
            else if (roll < 50 || (roll >= 72 && roll < 82))
            begin
                send_request(KIND_COMPUTE, CH_W'($urandom),
                             ROW_W'($urandom_range(0, rows - 1)),
                             COL_W'($urandom_range(0, cols - 1)),
                             ($urandom_range(0, 1) == 0) ? filt_a : filt_b,
                             VAL_W'($urandom));
            end
            else if (roll < 62)
            begin
                send_request(KIND_PIXEL, CH_W'($urandom_range(0, chans - 1)),
                             ROW_W'($urandom_range(0, rows - 1)),
                             COL_W'($urandom_range(0, cols - 1)),
                             FLT_W'($urandom), pick_value());
            end
            else if (roll < 72)
            begin
                send_request(KIND_WEIGHT, CH_W'($urandom_range(0, chans - 1)),
                             ROW_W'($urandom_range(0, ksize - 1)),
                             COL_W'($urandom_range(0, ksize - 1)),
                             FLT_W'($urandom), pick_value());
            end
            else if (roll < 95)
            begin
                send_request(($urandom_range(0, 1) == 0) ? KIND_WEIGHT : KIND_PIXEL,
                             CH_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                             FLT_W'($urandom), pick_value());
            end
            else
            begin
                send_request(KIND_UNUSED, CH_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom), FLT_W'($urandom), VAL_W'($urandom));
            end
        end
    endtask

    // Response ready: random stalls, long stretches without, and on request
    // one long hold-off so that the block backs up into its request port.
    initial
    begin
        int roll;
        int low_len;
        int high_len;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_requests > holds_served)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                low_len = (roll < 50) ? 0 : (roll < 90) ? $urandom_range(1, 3)
                                                         : $urandom_range(8, 40);
                if (low_len > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (low_len) @(posedge clk);
                end
                rsp_ch.ready <= 1'b1;
                high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
                repeat (high_len) @(posedge clk);
            end
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_WEIGHT;
        req_ch.channel      <= '0;
        req_ch.row          <= '0;
        req_ch.col          <= '0;
        req_ch.filter_index <= '0;
        req_ch.value        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases at the reset settings: a 3x3 kernel with extreme and small weights,
        // extreme pixels at the top-left and bottom-right corners, computes
        // whose windows hang over the padding, out-of-range writes and an unused kind.
        for (int i = 0; i < 9; i++)
        begin
            send_request(KIND_WEIGHT, '0, ROW_W'(i / 3), COL_W'(i % 3), '0, CORNER_WEIGHTS[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_request(KIND_PIXEL, '0, ROW_W'(i / 2), COL_W'(i % 2), '0,
                         (i == 0 || i == 3) ? VALUE_MAX : VALUE_MIN);
            send_request(KIND_PIXEL, '0, ROW_W'(30 + i / 2), COL_W'(30 + i % 2), '0, VALUE_MIN);
        end
        send_request(KIND_COMPUTE, CH_W'(5), '0, '0, '0, '0);
        send_request(KIND_COMPUTE, CH_W'(2), ROW_W'(31), COL_W'(31), '0, VALUE_MIN);
        send_request(KIND_WEIGHT, CH_W'(1), '0, '0, FLT_W'(3), VALUE_MAX);
        send_request(KIND_WEIGHT, '0, ROW_W'(3), '0, '0, VALUE_MIN);
        send_request(KIND_WEIGHT, '0, '0, COL_W'(31), FLT_W'(7), VALUE_MAX);
        send_request(KIND_PIXEL, CH_W'(7), ROW_W'(31), COL_W'(31), FLT_W'(7), VALUE_MIN);
        send_request(KIND_UNUSED, CH_W'(7), ROW_W'(31), COL_W'(31), FLT_W'(7), VALUE_MAX);

        // Register settings, including saturation of zero and of values above
        // the maximum, even kernel sides and the one-row and one-column images.
        run_phase(4, 5, 2, 1, 30, 1'b0);
        run_phase(0, 63, 0, 7, 30, 1'b0);
        run_phase(3, 3, 15, 1, 30, 1'b1);
        run_phase(5, 4, 3, 2, 30, 1'b0);
        run_phase(63, 2, 1, 4, 30, 1'b0);
        run_phase(6, 1, 2, 3, 30, 1'b0);

        wait_until_idle();
        if (pending_count != 0)
        begin
            $error("%0d expected responses never arrived", pending_count);
        end
        $display("Summary: %0d requests (%0d computes), %0d settings, %0d responses checked.",
                 requests_sent, computes_sent, settings_used, checked_count);
        $display({"Covered kernel sides 1 to 5, 1 to 8 channels, image sides 1 to 32",
                  " and a long response stall."});
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $error("timeout with %0d responses outstanding", pending_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule
